// ===== src/bsmm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bank select memory mapper package
// Shared item types, target codes, port decode constants and register indexes.
// ----------------------------------------------------------------------------
package bsmm_pkg;

  // Bus operation carried by one input item.
  typedef enum logic [1:0] {
    FUNC_MEM_READ   = 2'd0,
    FUNC_MEM_WRITE  = 2'd1,
    FUNC_PORT_WRITE = 2'd2,
    FUNC_PORT_READ  = 2'd3
  } func_t;

  // Memory that answers an access.
  typedef enum logic [2:0] {
    TGT_HOME_ROM  = 3'd0,
    TGT_HOME_RAM  = 3'd1,
    TGT_INT_EXROM = 3'd2,
    TGT_CART_DOCK = 3'd3,
    TGT_CART_EXROM = 3'd4,
    TGT_WROM      = 3'd5,
    TGT_NONE      = 3'd6,
    TGT_EXTERNAL  = 3'd7
  } target_t;

  // Configuration register indexes.
  localparam int unsigned CfgIndexWidth = 3;
  localparam logic [CfgIndexWidth-1:0] CFG_DOCK_READ_MASK   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_DOCK_WRITE_MASK  = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_EXROM_READ_MASK  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_EXROM_WRITE_MASK = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_HOME_WRITE_MASK  = 3'd4;

  // Port decode.
  localparam logic [7:0] PORT_WR_DECODE_MASK = 8'hF6;
  localparam logic [7:0] PORT_RD_DECODE_MASK = 8'hF7;
  localparam logic [7:0] PORT_DECODE_MATCH   = 8'hF4;
  localparam logic [3:0] PORT_CHUNK_SELECT   = 4'h4;
  localparam logic [3:0] PORT_BANK_DATA      = 4'hC;
  localparam logic [3:0] PORT_BANK_SELECTOR  = 4'hD;

  // Bank command selector codes and the command that latches the bank number.
  localparam logic [1:0] SEL_CMD         = 2'd1;
  localparam logic [1:0] SEL_HOLD_LOW    = 2'd2;
  localparam logic [1:0] SEL_HOLD_HIGH   = 2'd3;
  localparam logic [3:0] CMD_LATCH_BANK  = 4'hD;

  // Home RAM begins at chunk 2.
  localparam logic [15:0] HOME_RAM_BASE = 16'h4000;

  typedef struct packed {
    func_t       func;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        exrom_select;
    logic        romdis;
  } in_item_t;

  typedef struct packed {
    target_t     target;
    logic [15:0] mem_offset;
    logic        contended;
    logic [7:0]  read_data;
    logic [7:0]  read_drive_mask;
    logic [7:0]  bank_number;
  } out_item_t;

endpackage
`default_nettype wire

// ===== src/bank_select_memory_mapper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bank select memory mapper
// Translates CPU memory accesses to a target memory and offset per 8K chunk
// and decodes the chunk select and bank command ports.
// ----------------------------------------------------------------------------
// An accepted item is held in the input register and moves on to the result
// register when the output can take it, which makes the result valid.
// Throughput: one item per cycle; up to two items are held while the output
// is stalled, so input ready drops only when both registers are full.
// Reset clears all mapping state, configuration masks and valid flags at once.
module bank_select_memory_mapper (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire bsmm_pkg::in_item_t                in_item,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output bsmm_pkg::out_item_t                    out_item,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bsmm_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [7:0]                        cfg_data
);
  import bsmm_pkg::*;

  // Configuration masks, one bit per chunk.
  logic [7:0] dock_read_mask;
  logic [7:0] dock_write_mask;
  logic [7:0] exrom_read_mask;
  logic [7:0] exrom_write_mask;
  logic [7:0] home_write_mask;

  // Mapping state.
  logic [7:0] chunk_select, chunk_select_next;
  logic [1:0] bank_cmd_selector, bank_cmd_selector_next;
  logic [7:0] hold_register, hold_register_next;
  logic [7:0] bank_accessed, bank_accessed_next;

  // Input register.
  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_advance;
  out_item_t result;

  // Decode helpers for the held item.
  logic [2:0]  chunk;
  logic        is_mem;
  logic        is_write;
  logic [7:0]  rmask;
  logic [7:0]  wmask;
  target_t     cart_tgt;
  target_t     home_tgt;
  logic [15:0] home_off;
  logic [15:0] ram_off;
  logic        port_wr_hit;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      dock_read_mask   <= '0;
      dock_write_mask  <= '0;
      exrom_read_mask  <= '0;
      exrom_write_mask <= '0;
      home_write_mask  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DOCK_READ_MASK:   dock_read_mask   <= cfg_data;
        CFG_DOCK_WRITE_MASK:  dock_write_mask  <= cfg_data;
        CFG_EXROM_READ_MASK:  exrom_read_mask  <= cfg_data;
        CFG_EXROM_WRITE_MASK: exrom_write_mask <= cfg_data;
        CFG_HOME_WRITE_MASK:  home_write_mask  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register captures each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  // Shared decode of the held item.
  always_comb begin
    chunk    = s1_item.addr[15:13];
    is_mem   = (s1_item.func == FUNC_MEM_READ) || (s1_item.func == FUNC_MEM_WRITE);
    is_write = (s1_item.func == FUNC_MEM_WRITE);
    rmask    = s1_item.exrom_select ? exrom_read_mask : dock_read_mask;
    wmask    = s1_item.exrom_select ? exrom_write_mask : dock_write_mask;
    cart_tgt = s1_item.exrom_select ? TGT_CART_EXROM : TGT_CART_DOCK;
    ram_off  = s1_item.addr - HOME_RAM_BASE;
    // Home mapping: ROM in chunks 0 and 1 (writes per mask), RAM above.
    if (chunk[2:1] == 2'b00) begin
      if (!is_write) begin
        home_tgt = TGT_HOME_ROM;
        home_off = s1_item.addr;
      end else if (home_write_mask[chunk]) begin
        home_tgt = TGT_WROM;
        home_off = s1_item.addr;
      end else begin
        home_tgt = TGT_NONE;
        home_off = '0;
      end
    end else begin
      home_tgt = TGT_HOME_RAM;
      home_off = ram_off;
    end
  end

  // Result and next state for the held item.
  always_comb begin
    result                 = '0;
    result.target          = TGT_NONE;
    chunk_select_next      = chunk_select;
    bank_cmd_selector_next = bank_cmd_selector;
    hold_register_next     = hold_register;
    bank_accessed_next     = bank_accessed;
    port_wr_hit = (s1_item.addr[7:0] & PORT_WR_DECODE_MASK) == PORT_DECODE_MATCH;

    if (is_mem) begin
      result.contended = (chunk == 3'd2) || (chunk == 3'd3);
      if (s1_item.romdis && (chunk[2:1] == 2'b00)) begin
        result.target     = TGT_EXTERNAL;
        result.mem_offset = s1_item.addr;
      end else if (!chunk_select[chunk]) begin
        result.target     = home_tgt;
        result.mem_offset = home_off;
      end else if (!rmask[chunk] && !(s1_item.exrom_select && (chunk == 3'd0))) begin
        // No cartridge memory here: fall back to the home mapping.
        result.target     = home_tgt;
        result.mem_offset = home_off;
      end else if (!is_write && !rmask[chunk]) begin
        // Internal extension ROM answers reads in chunk 0.
        result.target     = TGT_INT_EXROM;
        result.mem_offset = {3'b000, s1_item.addr[12:0]};
      end else if (!is_write || wmask[chunk]) begin
        result.target     = cart_tgt;
        result.mem_offset = s1_item.addr;
      end else if (chunk[2:1] != 2'b00) begin
        result.target     = TGT_HOME_RAM;
        result.mem_offset = ram_off;
      end else begin
        result.target     = TGT_NONE;
        result.mem_offset = '0;
      end
    end else if (s1_item.func == FUNC_PORT_WRITE) begin
      if (port_wr_hit) begin
        case (s1_item.addr[3:0])
          PORT_CHUNK_SELECT:  chunk_select_next = s1_item.data;
          PORT_BANK_SELECTOR: bank_cmd_selector_next = s1_item.data[1:0];
          PORT_BANK_DATA: begin
            case (bank_cmd_selector)
              SEL_CMD: begin
                if (s1_item.data[3:0] == CMD_LATCH_BANK) begin
                  bank_accessed_next = hold_register;
                end
              end
              SEL_HOLD_LOW:  hold_register_next = {hold_register[7:4], s1_item.data[3:0]};
              SEL_HOLD_HIGH: hold_register_next = {s1_item.data[3:0], hold_register[3:0]};
              default: begin
              end
            endcase
          end
          default: begin
          end
        endcase
      end
    end else begin
      if ((s1_item.addr[7:0] & PORT_RD_DECODE_MASK) == PORT_DECODE_MATCH) begin
        result.read_data       = chunk_select;
        result.read_drive_mask = 8'hFF;
      end
    end
    result.bank_number = bank_accessed_next;
  end

  // State update when the held item moves to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_select      <= '0;
      bank_cmd_selector <= '0;
      hold_register     <= '0;
      bank_accessed     <= '0;
    end else if (s1_advance) begin
      chunk_select      <= chunk_select_next;
      bank_cmd_selector <= bank_cmd_selector_next;
      hold_register     <= hold_register_next;
      bank_accessed     <= bank_accessed_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
    if (s1_advance) begin
      out_item <= result;
    end
  end

`ifndef SYNTH
  // A driven port read never carries a memory target.
  a_port_read_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.read_drive_mask != 8'h00)) |->
      (out_item.read_drive_mask == 8'hFF) && (out_item.target == TGT_NONE))
    else $error("port read result has a bad drive mask or target");

  // Chunks 2 and 3 map only to home RAM or a cartridge bank.
  a_contended_target: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.contended) |->
      (out_item.target == TGT_HOME_RAM) || (out_item.target == TGT_CART_DOCK) ||
      (out_item.target == TGT_CART_EXROM))
    else $error("contended access mapped to an unexpected target");

  // Nothing is presented right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !s1_valid))
    else $error("result valid right after reset");

  // Input stalls only when both registers are full and the output is held.
  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without a full pipeline");
`endif

endmodule
`default_nettype wire
